/* sv/vfcm_pkg.sv */
// Package: shared types, constants and direction tables for the voxel face culling mesher
package vfcm_pkg;

   localparam int unsigned CHUNK_SIDE = 16;
   localparam int unsigned COORD_W = 4;
   localparam int unsigned VOL_CELLS = CHUNK_SIDE * CHUNK_SIDE * CHUNK_SIDE;
   localparam int unsigned LAYER_CELLS = CHUNK_SIDE * CHUNK_SIDE;
   localparam int unsigned VOL_AW = $clog2(VOL_CELLS);
   localparam int unsigned BND_AW = $clog2(6 * LAYER_CELLS);

   localparam logic [1:0] OP_LOAD_CHUNK = 2'd0;
   localparam logic [1:0] OP_LOAD_BND = 2'd1;
   localparam logic [1:0] OP_SCAN = 2'd2;
   localparam logic [1:0] OP_BEGIN = 2'd3;

   typedef struct packed {
      logic [1:0] operation;
      logic [3:0] block_x;
      logic [3:0] block_y;
      logic [3:0] block_z;
      logic [2:0] side;
      logic       solid;
   } req_type;

   typedef struct packed {
      logic [14:0] face_number;
      logic [1:0]  corner;
      logic [5:0]  pos_x;
      logic [5:0]  pos_y;
      logic [5:0]  pos_z;
      logic        tex_u;
      logic        tex_v;
      logic [2:0]  direction;
      logic        last;
   } rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic       capture;     // latch request beat
      logic       write_chunk; // write chunk store
      logic       write_bnd;   // write boundary store
      logic       clear_count; // begin mesh
      logic       read_self;   // read own block
      logic       read_nbr;    // read neighbour of dir
      logic [2:0] dir;
      logic       emit;        // drive a vertex
      logic [1:0] corner;
      logic       last;
      logic       bump_count;
   } cmd_type;

   // datapath -> controller status
   typedef struct packed {
      logic [1:0] operation;
      logic       self_solid;  // valid cycle after read_self
      logic       face_due;    // valid cycle after read_nbr
   } sts_type;

   // position offsets per direction for corner (u,v): n, r, d components (x,y,z)
   function automatic logic signed [2:0] dir_n(input logic [2:0] d, input int a);
      logic signed [2:0] r;
      r = 3'sd0;
      if (int'(d >> 1) == a) r = d[0] ? -3'sd1 : 3'sd1;
      return r;
   endfunction

   function automatic logic signed [2:0] dir_r(input logic [2:0] d, input int a);
      logic signed [2:0] r;
      r = 3'sd0;
      case (d)
         3'd0: if (a == 2) r = -3'sd1;
         3'd1: if (a == 2) r = 3'sd1;
         3'd2, 3'd4: if (a == 0) r = 3'sd1;
         3'd3, 3'd5: if (a == 0) r = -3'sd1;
         default: r = 3'sd0;
      endcase
      return r;
   endfunction

   function automatic logic signed [2:0] dir_d(input logic [2:0] d, input int a);
      logic signed [2:0] r;
      r = 3'sd0;
      case (d)
         3'd2, 3'd3: if (a == 2) r = 3'sd1;
         3'd0, 3'd1, 3'd4, 3'd5: if (a == 1) r = -3'sd1;
         default: r = 3'sd0;
      endcase
      return r;
   endfunction

endpackage

/* sv/vfcm_datapath.sv */
// Datapath: request register, solid stores, neighbour lookup, vertex math, face counter
module vfcm_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  vfcm_pkg::req_type      req_data,
   input  logic [5:0]             present,
   input  vfcm_pkg::cmd_type      cmd,
   output vfcm_pkg::sts_type      sts,
   output logic                   rsp_strobe,
   output vfcm_pkg::rsp_type      rsp_data
);

   vfcm_pkg::req_type req_ff;
   logic [14:0] count_ff;
   logic chunk_mem [vfcm_pkg::VOL_CELLS];
   logic bnd_mem [6 * vfcm_pkg::LAYER_CELLS];
   logic chunk_rd_ff, bnd_rd_ff, oob_ff, inside_ff, pres_ff;
   logic rsp_strobe_ff;
   vfcm_pkg::rsp_type rsp_ff, rsp_in;

   // latch request
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
   end

   // neighbour coordinate for the current direction
   logic [4:0] nx, ny, nz;
   logic       nbr_oob;
   always_comb begin
      nx = {1'b0, req_ff.block_x} + 5'(signed'(vfcm_pkg::dir_n(cmd.dir, 0)));
      ny = {1'b0, req_ff.block_y} + 5'(signed'(vfcm_pkg::dir_n(cmd.dir, 1)));
      nz = {1'b0, req_ff.block_z} + 5'(signed'(vfcm_pkg::dir_n(cmd.dir, 2)));
      nbr_oob = nx[4] | ny[4] | nz[4];
   end

   // store addresses
   logic [vfcm_pkg::VOL_AW-1:0] vol_addr, wr_vol;
   logic [vfcm_pkg::BND_AW-1:0] bnd_rd_addr, bnd_wr_addr;
   always_comb begin
      wr_vol = {req_ff.block_x, req_ff.block_y, req_ff.block_z};
      if (cmd.read_nbr) vol_addr = {nx[3:0], ny[3:0], nz[3:0]};
      else vol_addr = wr_vol;
      case (cmd.dir)
         3'd0, 3'd1: bnd_rd_addr = {cmd.dir, req_ff.block_y, req_ff.block_z};
         3'd2, 3'd3: bnd_rd_addr = {cmd.dir, req_ff.block_x, req_ff.block_z};
         default: bnd_rd_addr = {cmd.dir, req_ff.block_x, req_ff.block_y};
      endcase
      case (req_ff.side)
         3'd0, 3'd1: bnd_wr_addr = {req_ff.side, req_ff.block_y, req_ff.block_z};
         3'd2, 3'd3: bnd_wr_addr = {req_ff.side, req_ff.block_x, req_ff.block_z};
         default: bnd_wr_addr = {req_ff.side, req_ff.block_x, req_ff.block_y};
      endcase
   end

   // chunk store
   always_ff @(posedge clock) begin
      if (cmd.write_chunk) chunk_mem[wr_vol] <= req_ff.solid;
      chunk_rd_ff <= chunk_mem[vol_addr];
   end

   // boundary store
   always_ff @(posedge clock) begin
      if (cmd.write_bnd && req_ff.side < 3'd6) bnd_mem[bnd_wr_addr] <= req_ff.solid;
      bnd_rd_ff <= bnd_mem[bnd_rd_addr];
   end

   // lookup flags follow the read data
   always_ff @(posedge clock) begin
      oob_ff <= nbr_oob;
      pres_ff <= present[cmd.dir];
      inside_ff <= 1'b1;
   end

   assign sts.operation = req_ff.operation;
   assign sts.self_solid = inside_ff & chunk_rd_ff;
   assign sts.face_due = oob_ff ? (pres_ff & ~bnd_rd_ff) : ~chunk_rd_ff;

   // face counter
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_count) count_ff <= '0;
      else if (cmd.bump_count) count_ff <= count_ff + 15'd1;
   end

   // vertex position: 2b+1+n+r*su+d*sv
   logic [5:0] pos [3];
   logic [3:0] base [3];
   always_comb begin
      base[0] = req_ff.block_x;
      base[1] = req_ff.block_y;
      base[2] = req_ff.block_z;
      for (int a = 0; a < 3; a++) begin
         pos[a] = {1'b0, base[a], 1'b1}
                + 6'(signed'(vfcm_pkg::dir_n(cmd.dir, a)))
                + (cmd.corner[0] ? 6'(signed'(vfcm_pkg::dir_r(cmd.dir, a)))
                                 : -6'(signed'(vfcm_pkg::dir_r(cmd.dir, a))))
                + (cmd.corner[1] ? 6'(signed'(vfcm_pkg::dir_d(cmd.dir, a)))
                                 : -6'(signed'(vfcm_pkg::dir_d(cmd.dir, a))));
      end
      rsp_in.face_number = count_ff;
      rsp_in.corner = cmd.corner;
      rsp_in.pos_x = pos[0];
      rsp_in.pos_y = pos[1];
      rsp_in.pos_z = pos[2];
      rsp_in.tex_u = cmd.corner[0];
      rsp_in.tex_v = cmd.corner[1];
      rsp_in.direction = cmd.dir;
      rsp_in.last = cmd.last;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else rsp_strobe_ff <= cmd.emit;
      if (cmd.emit) rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data = rsp_ff;

endmodule

/* sv/vfcm_ctrl.sv */
// Controller: sequences loads, scan lookups and vertex emission
module vfcm_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vfcm_pkg::sts_type sts,
   output vfcm_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_SELF = 3'd2;
   localparam logic [2:0] ST_LOOK = 3'd3;
   localparam logic [2:0] ST_CHECK = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [2:0] dir_ff, dir_in;
   logic [1:0] corner_ff, corner_in;
   logic [5:0] due_ff, due_in;   // due mask gathered over the lookups

   // lookups run first for all six directions, then vertices stream out
   logic       more_after;
   always_comb begin
      more_after = 1'b0;
      for (int d = 0; d < 6; d++)
         if (d > int'(dir_ff) && due_ff[d]) more_after = 1'b1;
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      dir_in = dir_ff;
      corner_in = corner_ff;
      due_in = due_ff;
      cmd = '0;
      cmd.dir = dir_ff;
      cmd.corner = corner_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.operation)
               vfcm_pkg::OP_LOAD_CHUNK: begin
                  cmd.write_chunk = 1'b1;
                  state_in = ST_IDLE;
               end
               vfcm_pkg::OP_LOAD_BND: begin
                  cmd.write_bnd = 1'b1;
                  state_in = ST_IDLE;
               end
               vfcm_pkg::OP_BEGIN: begin
                  cmd.clear_count = 1'b1;
                  state_in = ST_IDLE;
               end
               default: begin
                  cmd.read_self = 1'b1;
                  dir_in = 3'd0;
                  due_in = '0;
                  state_in = ST_SELF;
               end
            endcase
         end
         ST_SELF: begin
            if (!sts.self_solid) state_in = ST_IDLE;
            else begin
               cmd.read_nbr = 1'b1;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            due_in[dir_ff] = sts.face_due;
            if (dir_ff == 3'd5) state_in = ST_CHECK;
            else begin
               dir_in = dir_ff + 3'd1;
               cmd.dir = dir_in;
               cmd.read_nbr = 1'b1;
            end
         end
         ST_CHECK: begin
            // find first due direction
            state_in = ST_IDLE;
            dir_in = 3'd0;
            for (int d = 5; d >= 0; d--)
               if (due_ff[d]) begin
                  dir_in = 3'(d);
                  state_in = ST_EMIT;
               end
            corner_in = 2'd0;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            cmd.last = (corner_ff == 2'd3) && !more_after;
            corner_in = corner_ff + 2'd1;
            if (corner_ff == 2'd3) begin
               cmd.bump_count = 1'b1;
               if (!more_after) state_in = ST_IDLE;
               else
                  for (int d = 0; d < 6; d++)
                     if (d > int'(dir_ff) && due_ff[d] && dir_in == dir_ff)
                        dir_in = 3'(d);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dir_ff <= '0;
         corner_ff <= '0;
         due_ff <= '0;
      end else begin
         state_ff <= state_in;
         dir_ff <= dir_in;
         corner_ff <= corner_in;
         due_ff <= due_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // checks
   a_emit_only_in_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> state_ff == ST_EMIT) else $error("emit outside emit state");
   a_bump_on_last_corner: assert property (@(posedge clock) disable iff (reset)
      cmd.bump_count |-> corner_ff == 2'd3) else $error("count bump mid face");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      cmd.last |=> state_ff == ST_IDLE) else $error("last not final");
   a_emit_due: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> due_ff[dir_ff]) else $error("emit for culled face");
endmodule

/* sv/voxel_face_cull_mesher_top.sv */
// Top level: voxel face culling mesher, controller plus datapath
// Usage:
//   Request channel: drive req_data and raise start; the beat is taken at an
//   edge with start high and busy low. Operations: load chunk block, load
//   neighbour boundary cell, scan block, begin mesh (clears face counter).
//   Response channel: each vertex beat is on rsp_data for one cycle with
//   rsp_strobe high; the receiver cannot stall, every beat must be taken.
//   rsp_data.last marks the final vertex of a scan.
//   CSR channel: csr_valid/csr_ready write the neighbour present mask; write
//   only while busy is low. csr_ready is always high.
// Sequence, one item at a time, set by the controller:
//   loads and begin mesh: idle, then decode, the only state with busy high.
//   scan of air block: decode, self read, back to idle; solid block: self
//   read, lookups (one store read per direction), a check state, then one
//   vertex per corner of each emitted face, through the output register.
// Reset: controller idle, face counter and neighbour mask zero. Chunk and
//   boundary stores are not cleared; load every cell before scanning it.
module voxel_face_cull_mesher_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  vfcm_pkg::req_type req_data,
   output logic              rsp_strobe,
   output vfcm_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [5:0]        csr_data
);

   logic [5:0] present_ff;
   vfcm_pkg::cmd_type cmd;
   vfcm_pkg::sts_type sts;

   // neighbour present register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) present_ff <= '0;
      else if (csr_valid) present_ff <= csr_data;
   end

   vfcm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .sts(sts), .cmd(cmd)
   );

   vfcm_datapath u_dp (
      .clock(clock), .reset(reset), .req_data(req_data), .present(present_ff),
      .cmd(cmd), .sts(sts), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

endmodule

/* tb/tb_voxel_face_cull_mesher_top.sv */
// Testbench for the voxel face culling mesher: predicts vertex beats and checks them in order
`timescale 1ns / 100ps

// Holds the mesher's predicted state and the queue of vertex beats still due
class mesh_vertex_book;
   bit chunk_bit[4096];
   bit chunk_set[4096];
   bit bnd_bit[1536];
   bit bnd_set[1536];
   bit [14:0] face_cnt;
   bit [5:0] present;
   vfcm_pkg::rsp_type due_q[$];
   int errors;

   // normal, right and down vectors per direction
   int nrm[6][3] = '{'{1, 0, 0}, '{-1, 0, 0}, '{0, 1, 0}, '{0, -1, 0}, '{0, 0, 1}, '{0, 0, -1}};
   int rgt[6][3] = '{'{0, 0, -1}, '{0, 0, 1}, '{1, 0, 0}, '{-1, 0, 0}, '{1, 0, 0}, '{-1, 0, 0}};
   int dwn[6][3] = '{'{0, -1, 0}, '{0, -1, 0}, '{0, 0, 1}, '{0, 0, 1}, '{0, -1, 0}, '{0, -1, 0}};

   function int vol(int x, int y, int z);
      return (x * 16 + y) * 16 + z;
   endfunction

   function int lay(int s, int x, int y, int z);
      if (s < 2) return s * 256 + y * 16 + z;
      if (s < 4) return s * 256 + x * 16 + z;
      return s * 256 + x * 16 + y;
   endfunction

   function bit on_chunk(int c[3]);
      return c[0] >= 0 && c[1] >= 0 && c[2] >= 0 && c[0] < 16 && c[1] < 16 && c[2] < 16;
   endfunction

   // true when a scan of this block reads only cells already loaded
   function bit reads_ok(int x, int y, int z);
      int c[3];
      if (!chunk_set[vol(x, y, z)]) return 0;
      if (!chunk_bit[vol(x, y, z)]) return 1;
      for (int d = 0; d < 6; d++) begin
         c[0] = x + nrm[d][0];
         c[1] = y + nrm[d][1];
         c[2] = z + nrm[d][2];
         if (on_chunk(c)) begin
            if (!chunk_set[vol(c[0], c[1], c[2])]) return 0;
         end else if (present[d] && !bnd_set[lay(d, x, y, z)]) return 0;
      end
      return 1;
   endfunction

   function bit face_due(int x, int y, int z, int d);
      int c[3];
      c[0] = x + nrm[d][0];
      c[1] = y + nrm[d][1];
      c[2] = z + nrm[d][2];
      if (on_chunk(c)) return !chunk_bit[vol(c[0], c[1], c[2])];
      if (!present[d]) return 0;
      return !bnd_bit[lay(d, x, y, z)];
   endfunction

   // accepted request beat: update state and queue the vertices it causes
   function void note_beat(vfcm_pkg::req_type r);
      int x, y, z, su, sv, p;
      vfcm_pkg::rsp_type v;
      int first;
      x = r.block_x;
      y = r.block_y;
      z = r.block_z;
      first = due_q.size();
      case (r.operation)
         vfcm_pkg::OP_BEGIN: face_cnt = '0;
         vfcm_pkg::OP_LOAD_CHUNK: begin
            chunk_bit[vol(x, y, z)] = r.solid;
            chunk_set[vol(x, y, z)] = 1;
         end
         vfcm_pkg::OP_LOAD_BND: begin
            if (r.side < 6) begin
               bnd_bit[lay(r.side, x, y, z)] = r.solid;
               bnd_set[lay(r.side, x, y, z)] = 1;
            end
         end
         default: begin
            if (chunk_bit[vol(x, y, z)]) begin
               for (int d = 0; d < 6; d++) begin
                  if (face_due(x, y, z, d)) begin
                     for (int k = 0; k < 4; k++) begin
                        su = (k & 1) * 2 - 1;
                        sv = (k >> 1) * 2 - 1;
                        v.face_number = face_cnt;
                        v.corner = k;
                        p = 2 * x + 1 + nrm[d][0] + rgt[d][0] * su + dwn[d][0] * sv;
                        v.pos_x = p[5:0];
                        p = 2 * y + 1 + nrm[d][1] + rgt[d][1] * su + dwn[d][1] * sv;
                        v.pos_y = p[5:0];
                        p = 2 * z + 1 + nrm[d][2] + rgt[d][2] * su + dwn[d][2] * sv;
                        v.pos_z = p[5:0];
                        v.tex_u = k & 1;
                        v.tex_v = k >> 1;
                        v.direction = d;
                        v.last = 0;
                        due_q = {due_q, v};
                     end
                     face_cnt = face_cnt + 1;
                  end
               end
               if (due_q.size() > first) due_q[due_q.size() - 1].last = 1;
            end
         end
      endcase
   endfunction

   function void field(string name, int e, int a);
      if (e != a) begin
         $display("%0t: vertex %s mismatch, expected %0d, actual %0d", $time, name, e, a);
         errors++;
      end
   endfunction

   // compare one vertex beat with the oldest prediction
   function void check_vertex(vfcm_pkg::rsp_type a);
      vfcm_pkg::rsp_type e;
      if (due_q.size() == 0) begin
         $display("%0t: unexpected vertex beat, expected none, actual %h", $time, a);
         errors++;
         return;
      end
      e = due_q.pop_front();
      field("face_number", e.face_number, a.face_number);
      field("corner", e.corner, a.corner);
      field("pos_x", e.pos_x, a.pos_x);
      field("pos_y", e.pos_y, a.pos_y);
      field("pos_z", e.pos_z, a.pos_z);
      field("tex_u", e.tex_u, a.tex_u);
      field("tex_v", e.tex_v, a.tex_v);
      field("direction", e.direction, a.direction);
      field("last", e.last, a.last);
   endfunction
endclass

module tb_voxel_face_cull_mesher_top;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   vfcm_pkg::req_type req_data = '0;
   logic rsp_strobe;
   vfcm_pkg::rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [5:0] csr_data = '0;

   mesh_vertex_book book = new();
   int sent = 0;
   int cycles = 0;
   bit calm = 0;

   voxel_face_cull_mesher_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // vertex beats are taken on every strobe
   always @(posedge clock) begin
      if (!reset && rsp_strobe) book.check_vertex(rsp_data);
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("tb_voxel_face_cull_mesher_top: done, errors");
         $finish;
      end
   end

   // one request beat, at times with a random idle before it when not calm
   task automatic send(vfcm_pkg::req_type r);
      if (!calm && $urandom_range(99) < 33) begin
         start <= 0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      start <= 1;
      req_data <= r;
      do @(posedge clock); while (busy);
      book.note_beat(r);
      sent++;
   endtask

   task automatic send_op(logic [1:0] op, int x, int y, int z, int s, bit sol);
      vfcm_pkg::req_type r;
      r.operation = op;
      r.block_x = x;
      r.block_y = y;
      r.block_z = z;
      r.side = s;
      r.solid = sol;
      send(r);
   endtask

   // hold off until every vertex has come and the block has gone quiet
   task automatic drain();
      start <= 0;
      while (book.due_q.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mask(bit [5:0] m);
      drain();
      csr_valid <= 1;
      csr_data <= m;
      do @(posedge clock); while (!csr_ready);
      book.present = m;
      csr_valid <= 0;
   endtask

   // load a block and all it touches, then scan it
   task automatic scan_group(int x, int y, int z, bit self_s, int air_pct);
      int c[3];
      send_op(vfcm_pkg::OP_LOAD_CHUNK, x, y, z, $urandom_range(7), self_s);
      for (int d = 0; d < 6; d++) begin
         c[0] = x + book.nrm[d][0];
         c[1] = y + book.nrm[d][1];
         c[2] = z + book.nrm[d][2];
         if (book.on_chunk(c))
            send_op(vfcm_pkg::OP_LOAD_CHUNK, c[0], c[1], c[2], $urandom_range(7),
                    $urandom_range(99) >= air_pct);
         else
            send_op(vfcm_pkg::OP_LOAD_BND, x, y, z, d, $urandom_range(99) >= air_pct);
      end
      send_op(vfcm_pkg::OP_SCAN, x, y, z, $urandom_range(7), $urandom_range(1));
   endtask

   function automatic int pick();
      int k;
      k = $urandom_range(9);
      if (k == 0) return 0;
      if (k == 1) return 15;
      return $urandom_range(15);
   endfunction

   initial begin
      int x, y, z, k;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: corners with mask off and on, bad side, air block
      send_op(vfcm_pkg::OP_BEGIN, 0, 0, 0, 0, 0);
      scan_group(0, 0, 0, 1, 100);
      write_mask(6'h3f);
      send_op(vfcm_pkg::OP_SCAN, 0, 0, 0, 0, 0);
      scan_group(15, 15, 15, 1, 100);
      send_op(vfcm_pkg::OP_LOAD_BND, 15, 15, 15, 7, 1);
      send_op(vfcm_pkg::OP_LOAD_BND, 15, 15, 15, 6, 0);
      send_op(vfcm_pkg::OP_LOAD_CHUNK, 5, 5, 5, 0, 0);
      send_op(vfcm_pkg::OP_SCAN, 5, 5, 5, 0, 0);

      // random traffic
      while (sent < 250) begin
         if (sent > 120 && sent < 175) calm = 1;
         else calm = 0;
         if ($urandom_range(59) == 0) write_mask($urandom_range(63));
         else if ($urandom_range(79) == 0) drain();
         k = $urandom_range(99);
         x = pick();
         y = pick();
         z = pick();
         if (k < 65) scan_group(x, y, z, $urandom_range(9) != 0, $urandom_range(10, 90));
         else if (k < 72)
            send_op(vfcm_pkg::OP_BEGIN, x, y, z, $urandom_range(7), $urandom_range(1));
         else if (k < 82)
            send_op(vfcm_pkg::OP_LOAD_CHUNK, x, y, z, $urandom_range(7), $urandom_range(1));
         else if (k < 92)
            send_op(vfcm_pkg::OP_LOAD_BND, x, y, z, $urandom_range(7), $urandom_range(1));
         else if (book.reads_ok(x, y, z))
            send_op(vfcm_pkg::OP_SCAN, x, y, z, $urandom_range(7), $urandom_range(1));
         if (sent > 200 && sent < 215) write_mask(6'h00);
      end
      write_mask(6'h15);
      scan_group(15, 0, 15, 1, 50);

      drain();
      repeat (40) @(posedge clock);
      if (book.errors == 0 && book.due_q.size() == 0)
         $display("tb_voxel_face_cull_mesher_top: done, clean");
      else
         $display("tb_voxel_face_cull_mesher_top: done, errors");
      $finish;
   end
endmodule
